[design/atp_pkg.sv]
package atp_pkg;

  localparam int ANGLE_STEPS  = 16;
  localparam int TABLE_LEN    = 24;
  localparam int SQRT_STEPS   = 31;
  localparam int SQRT_IN_W    = 2 * SQRT_STEPS;
  localparam int SQRT_REM_W   = SQRT_STEPS + 2;
  localparam int CORDIC_W     = 48;
  localparam int ANG_W        = 26;
  localparam int TAB_W        = 21;
  localparam int PRE_STAGES   = 3;
  localparam int PIPE_DEPTH   = PRE_STAGES + SQRT_STEPS + ANGLE_STEPS;
  localparam int CORDIC_START = PRE_STAGES + SQRT_STEPS - 1;

  // Arctangent of 2^-k in 1/256 centidegree.
  localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
    21'd22916, 21'd11459, 21'd5730, 21'd2865, 21'd1432, 21'd716,
    21'd358, 21'd179, 21'd90, 21'd45, 21'd22, 21'd11,
    21'd6, 21'd3, 21'd1, 21'd1, 21'd0, 21'd0
  };

  localparam logic        REG_SHAKE   = 1'b0;
  localparam logic        REG_FACE    = 1'b1;
  localparam logic [15:0] SHAKE_RESET = 16'd8192;
  localparam logic [14:0] FACE_RESET  = 15'd2867;

  typedef enum logic [2:0] {
    ORIENT_FACE_UP     = 3'd0,
    ORIENT_FACE_DOWN   = 3'd1,
    ORIENT_PORTRAIT    = 3'd2,
    ORIENT_INVERTED    = 3'd3,
    ORIENT_LAND_RIGHT  = 3'd4,
    ORIENT_LAND_LEFT   = 3'd5
  } orient_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } atp_side_t;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic [2:0]         orient;
    logic [15:0]        mag;
    logic               shaken;
  } atp_result_t;

endpackage

[design/atp_ifs.sv]
interface atp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atp_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] roll_centideg;
  logic [2:0]         orientation_code;
  logic [15:0]        magnitude;
  logic               shaken;
  modport source (output valid, pitch_centideg, roll_centideg, orientation_code,
                  magnitude, shaken, input ready);
  modport sink (input valid, pitch_centideg, roll_centideg, orientation_code,
                magnitude, shaken, output ready);
endinterface

[design/atp_isqrt.sv]
module atp_isqrt import atp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [SQRT_IN_W-1:0]  rad_i,
  output logic [SQRT_STEPS-1:0] root_o
);

  logic [SQRT_REM_W-1:0] rem_q  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] root_q [SQRT_STEPS];
  logic [SQRT_IN_W-1:0]  rest_q [SQRT_STEPS];

  // One result bit per stage, from the top pair of input bits down.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [SQRT_REM_W-1:0] rem_in, rem_s, trial;
    logic [SQRT_STEPS-1:0] root_in;
    logic [SQRT_IN_W-1:0]  rest_in;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rest_in = rest_q[k-1];
    end

    assign rem_s = {rem_in[SQRT_REM_W-3:0], rest_in[SQRT_IN_W-1:SQRT_IN_W-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rem_s >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_s - trial) : rem_s;
        root_q[k] <= {root_in[SQRT_STEPS-2:0], ge};
        rest_q[k] <= {rest_in[SQRT_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule

[design/atp_cordic.sv]
module atp_cordic import atp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  output logic signed [ANG_W-1:0]    ang_o
);

  logic signed [CORDIC_W-1:0] x_q [ANGLE_STEPS];
  logic signed [CORDIC_W-1:0] y_q [ANGLE_STEPS];
  logic signed [ANG_W-1:0]    a_q [ANGLE_STEPS];

  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_rot
    logic signed [CORDIC_W-1:0] x_in, y_in, dx, dy;
    logic signed [ANG_W-1:0]    a_in, step;

    if (k == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign a_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign a_in = a_q[k-1];
    end

    assign dx   = y_in >>> k;
    assign dy   = x_in >>> k;
    assign step = $signed({{(ANG_W-TAB_W){1'b0}}, ATAN_TAB[k]});

    // Rotate toward the x axis; the sign of y picks the direction.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[CORDIC_W-1]) begin
          x_q[k] <= x_in + dx;
          y_q[k] <= y_in - dy;
          a_q[k] <= a_in + step;
        end else begin
          x_q[k] <= x_in - dx;
          y_q[k] <= y_in + dy;
          a_q[k] <= a_in - step;
        end
      end
    end
  end

  assign ang_o = a_q[ANGLE_STEPS-1];

endmodule

[design/accel_tilt_orientation.sv]
// Throughput: one request per cycle while the skid entry is empty; the fixed
// pipeline depth comes from the input squaring stages, the 31-stage square
// root and the 16-stage CORDIC rotation chain.
// A skid stage behind the output register keeps in_if.ready free of out_if.ready.
// Reset: rst_ni clears all valid bits, and the shake and face thresholds
// return to 8192 and 2867.
module accel_tilt_orientation import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  atp_in_if.sink      in_if,
  atp_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] shake_q;
  logic [14:0] face_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shake_q <= SHAKE_RESET;
      face_q  <= FACE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SHAKE: shake_q <= pwdata[15:0];
        REG_FACE:  face_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SHAKE: prdata = {16'd0, shake_q};
      REG_FACE:  prdata = {17'd0, face_q};
      default:   prdata = '0;
    endcase
  end

  // Pipeline control.
  logic        en;
  logic        skid_vld_q, out_vld_q;
  logic        vld_q [PIPE_DEPTH];
  atp_side_t   side_q [PIPE_DEPTH];
  atp_result_t res_d, out_q, skid_q;

  assign en          = !skid_vld_q;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_if.valid;
      for (int k = 1; k < PIPE_DEPTH; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{x: in_if.accel_x, y: in_if.accel_y, z: in_if.accel_z};
      for (int k = 1; k < PIPE_DEPTH; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Squares, then the two sums of squares.
  logic signed [31:0] sx, sy, sz;
  logic [30:0]        x2_q, y2_q, z2_q;
  logic [31:0]        yz2_q, all2_q;

  assign sx = side_q[0].x * side_q[0].x;
  assign sy = side_q[0].y * side_q[0].y;
  assign sz = side_q[0].z * side_q[0].z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q   <= sx[30:0];
      y2_q   <= sy[30:0];
      z2_q   <= sz[30:0];
      yz2_q  <= {1'b0, y2_q} + {1'b0, z2_q};
      all2_q <= {1'b0, y2_q} + {1'b0, z2_q} + {1'b0, x2_q};
    end
  end

  // Both roots carry 15 fraction bits; the magnitude drops them.
  logic [SQRT_STEPS-1:0] rad_root, mag_root;

  atp_isqrt u_sqrt_rad (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({yz2_q, 30'd0}),
    .root_o (rad_root)
  );

  atp_isqrt u_sqrt_mag (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({all2_q, 30'd0}),
    .root_o (mag_root)
  );

  logic [15:0] mag_q [ANGLE_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= mag_root[30:15];
      for (int k = 1; k < ANGLE_STEPS; k++) mag_q[k] <= mag_q[k-1];
    end
  end

  // CORDIC operands.
  atp_side_t                  sc;
  logic signed [CORDIC_W-1:0] px, py, rx, ry, xn;
  logic signed [16:0]         zz, yy;

  assign sc = side_q[CORDIC_START];
  assign xn = -$signed({{(CORDIC_W-16){sc.x[15]}}, sc.x});
  assign px = $signed({5'd0, rad_root, 12'd0});
  assign py = $signed({xn[20:0], 27'd0});
  // For negative z the vector is turned by half a turn first.
  assign zz = sc.z[15] ? -$signed({sc.z[15], sc.z}) : $signed({sc.z[15], sc.z});
  assign yy = sc.z[15] ? -$signed({sc.y[15], sc.y}) : $signed({sc.y[15], sc.y});
  assign rx = $signed({{4{zz[16]}}, zz, 27'd0});
  assign ry = $signed({{4{yy[16]}}, yy, 27'd0});

  logic signed [ANG_W-1:0] pitch_ang, roll_ang;

  atp_cordic u_cordic_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (px),
    .y_i   (py),
    .ang_o (pitch_ang)
  );

  atp_cordic u_cordic_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (rx),
    .y_i   (ry),
    .ang_o (roll_ang)
  );

  // Final stage: rounding, clamping, orientation and shake flag.
  atp_side_t               sl;
  logic signed [ANG_W-1:0] roll_full, pr, rr;
  logic signed [17:0]      zs, ft;
  logic [16:0]             ax, ay;
  logic                    pnz, rnz;

  assign sl = side_q[PIPE_DEPTH-1];

  always_comb begin
    rnz = (sl.y != 16'sd0) || (sl.z != 16'sd0);
    pnz = rnz || (sl.x != 16'sd0);

    roll_full = roll_ang;
    if (sl.z[15]) begin
      roll_full = sl.y[15] ? (roll_ang - ANG_W'(18000 * 256))
                           : (roll_ang + ANG_W'(18000 * 256));
    end

    pr = (pitch_ang + ANG_W'(128)) >>> 8;
    rr = (roll_full + ANG_W'(128)) >>> 8;
    if (pr > ANG_W'(9000))  pr = ANG_W'(9000);
    if (pr < -ANG_W'(9000)) pr = -ANG_W'(9000);
    if (rr > ANG_W'(18000))  rr = ANG_W'(18000);
    if (rr < -ANG_W'(18000)) rr = -ANG_W'(18000);

    res_d.pitch = pnz ? pr[14:0] : 15'sd0;
    res_d.roll  = rnz ? rr[15:0] : 16'sd0;

    zs = {{2{sl.z[15]}}, sl.z};
    ft = {3'd0, face_q};
    ax = sl.x[15] ? 17'(-{sl.x[15], sl.x}) : {1'b0, sl.x};
    ay = sl.y[15] ? 17'(-{sl.y[15], sl.y}) : {1'b0, sl.y};

    priority if (zs > ft) begin
      res_d.orient = ORIENT_FACE_UP;
    end else if (zs + ft < 18'sd0) begin
      res_d.orient = ORIENT_FACE_DOWN;
    end else if (ay >= ax) begin
      res_d.orient = sl.y[15] ? ORIENT_INVERTED : ORIENT_PORTRAIT;
    end else begin
      res_d.orient = sl.x[15] ? ORIENT_LAND_LEFT : ORIENT_LAND_RIGHT;
    end

    res_d.mag    = mag_q[ANGLE_STEPS-1];
    res_d.shaken = (mag_q[ANGLE_STEPS-1] > shake_q);
  end

  // Output register with a skid entry behind it.
  logic push, pop;

  assign push = en && vld_q[PIPE_DEPTH-1];
  assign pop  = out_vld_q && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_if.valid            = out_vld_q;
  assign out_if.pitch_centideg   = out_q.pitch;
  assign out_if.roll_centideg    = out_q.roll;
  assign out_if.orientation_code = out_q.orient;
  assign out_if.magnitude        = out_q.mag;
  assign out_if.shaken           = out_q.shaken;

endmodule

[verif/tb_top.sv]
module tb_top;
  import atp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_LUT [24] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt = 0;
  logic        calm = 1'b0;

  atp_in_if  in_if ();
  atp_out_if out_if ();

  accel_tilt_orientation u_dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  class tilt_scoreboard;
    atp_result_t pending_q[$];
    longint      shake_lim = 8192;
    longint      face_lim = 2867;

    function longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function longint vector_angle(longint xv, longint yv);
      longint ang, dx, dy;
      ang = 0;
      for (int i = 0; i < ((ANGLE_STEPS > 24) ? 24 : ANGLE_STEPS); i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv += dx; yv -= dy; ang += ATAN_LUT[i];
        end else begin
          xv -= dx; yv += dy; ang -= ATAN_LUT[i];
        end
      end
      return ang;
    endfunction

    function longint centideg(longint ang, longint lim);
      longint r;
      r = (ang + 128) >>> 8;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function void note_sample(atp_side_t s);
      longint x, y, z, yz2, mag, ang, ax, ay, rad;
      atp_result_t r;
      x = s.x; y = s.y; z = s.z;
      yz2 = y * y + z * z;
      r = '0;
      if (x != 0 || yz2 != 0) begin
        rad = root_floor(yz2 <<< 30);
        r.pitch = 15'(centideg(vector_angle(rad * 4096, -x * 32768 * 4096), 9000));
      end
      if (yz2 != 0) begin
        if (z >= 0) begin
          ang = vector_angle(z * 134217728, y * 134217728);
        end else begin
          ang = vector_angle(-z * 134217728, -y * 134217728);
          ang += (y >= 0) ? 18000 * 256 : -18000 * 256;
        end
        r.roll = 16'(centideg(ang, 18000));
      end
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (z > face_lim) r.orient = ORIENT_FACE_UP;
      else if (z < -face_lim) r.orient = ORIENT_FACE_DOWN;
      else if (ay >= ax) r.orient = (y >= 0) ? ORIENT_PORTRAIT : ORIENT_INVERTED;
      else r.orient = (x >= 0) ? ORIENT_LAND_RIGHT : ORIENT_LAND_LEFT;
      mag = root_floor(yz2 + x * x);
      if (mag > 65535) mag = 65535;
      r.mag = 16'(mag);
      r.shaken = mag > shake_lim;
      pending_q.push_back(r);
    endfunction

    function int check_result(atp_result_t got);
      atp_result_t exp_r;
      int bad;
      bad = 0;
      if (pending_q.size() == 0) begin
        $error("unexpected result %p", got);
        return 1;
      end
      exp_r = pending_q.pop_front();
      if (got.pitch !== exp_r.pitch) begin
        $error("pitch_centideg exp %0d got %0d", exp_r.pitch, got.pitch); bad = 1;
      end
      if (got.roll !== exp_r.roll) begin
        $error("roll_centideg exp %0d got %0d", exp_r.roll, got.roll); bad = 1;
      end
      if (got.orient !== exp_r.orient) begin
        $error("orientation_code exp %0d got %0d", exp_r.orient, got.orient); bad = 1;
      end
      if (got.mag !== exp_r.mag) begin
        $error("magnitude exp %0d got %0d", exp_r.mag, got.mag); bad = 1;
      end
      if (got.shaken !== exp_r.shaken) begin
        $error("shaken exp %0d got %0d", exp_r.shaken, got.shaken); bad = 1;
      end
      return bad;
    endfunction
  endclass

  tilt_scoreboard tilt_sb = new();

  initial begin
    in_if.valid = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: random stall bursts, none once the run turns calm.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    atp_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.pitch = out_if.pitch_centideg;
      got.roll = out_if.roll_centideg;
      got.orient = out_if.orientation_code;
      got.mag = out_if.magnitude;
      got.shaken = out_if.shaken;
      fail_cnt += tilt_sb.check_result(got);
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_SHAKE) tilt_sb.shake_lim = val[15:0];
    else tilt_sb.face_lim = val[14:0];
  endtask

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input bit may_gap);
    int gap;
    if (may_gap && !calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.accel_x <= x; in_if.accel_y <= y; in_if.accel_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    tilt_sb.note_sample('{x: x, y: y, z: z});
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (tilt_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 8192)) - 4096);
      3: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a;
    @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Zero vectors, axis extremes, |x| = |y| ties, z < 0 with y = 0.
    send_sample(0, 0, 0, 0);
    send_sample(16'h8000, 0, 0, 0);
    send_sample(16'h7FFF, 0, 0, 0);
    send_sample(0, 0, 16'h8000, 0);
    send_sample(0, 0, 16'h7FFF, 0);
    send_sample(0, 16'h8000, 0, 0);
    send_sample(0, 16'h7FFF, 0, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
    send_sample(100, 100, 0, 0);
    send_sample(-100, -100, 0, 0);
    send_sample(100, -50, 0, 0);
    send_sample(-100, 50, 0, 0);
    send_sample(0, 0, -1, 0);
    send_sample(0, -1, -1, 0);
    send_sample(0, 0, 2867, 0);
    send_sample(0, 0, 2868, 0);
    send_sample(0, 0, -2868, 0);
    send_sample(4096, 4096, 4096, 0);
    drop_valid();
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_SHAKE, 0); write_reg(REG_FACE, 0); end
        1: begin write_reg(REG_SHAKE, 32'hFFFF); write_reg(REG_FACE, 32'h7FFF); end
        2: begin write_reg(REG_SHAKE, 4096); write_reg(REG_FACE, 1000); end
        default: begin
          write_reg(REG_SHAKE, $urandom_range(0, 65535));
          write_reg(REG_FACE, $urandom_range(0, 32767));
        end
      endcase
      if (ph == 4) calm = 1'b1;
      for (int n = 0; n < 400; n++) begin
        if ($urandom_range(0, 1)) a = 16'($urandom);
        else a = rand_axis();
        send_sample(rand_axis(), a, rand_axis(), 1);
        if (!calm && $urandom_range(0, 3) == 0) drop_valid();
        if (n == 200 && ph == 1) begin
          drop_valid();
          while (tilt_sb.pending_q.size() != 0) @(negedge clk_i);
        end
      end
      drop_valid();
      drain();
    end
    if (fail_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

[filelist.f]
design/atp_pkg.sv
design/atp_ifs.sv
design/atp_isqrt.sv
design/atp_cordic.sv
design/accel_tilt_orientation.sv
verif/tb_top.sv
